### src/egcd_pkg.sv
// shared types for the extended gcd and modular inverse block
`timescale 1ns / 1ps

package egcd_pkg;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_FIN
   } egcd_state_type;

endpackage

### src/extended_gcd_mod_inverse_top.sv
// extended euclid gcd, bezout coefficients and modular inverse on a shared divide step
//
// channel  direction  tdata (low bit first)                        tuser
// req      in         operand_a, modulus_b                         -
// rsp      out        gcd_value, coef_x, coef_y, inverse, zeros    inverse_exists
//
// each euclid step is a restoring divide, one quotient bit a cycle through the shared
// compare/subtract unit; the word is loaded in ST_IDLE and the result is written in
// ST_FIN, and a word with modulus_b of 0 goes from the load straight to ST_FIN.
// reset is synchronous and clears the sequencer and the result valid.
// a new word is taken while a finished result still waits on rsp; a result that is
// ready while the previous one is not yet taken holds the sequencer in its last state.
`timescale 1ns / 1ps

module extended_gcd_mod_inverse_top
   import egcd_pkg::*;
#(
   parameter int WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // operand_a, modulus_b, zero fill
   input  logic [((2*WIDTH+7)/8)*8-1:0]        req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // gcd_value, coef_x, coef_y, inverse, zero fill
   output logic [((4*WIDTH+2+7)/8)*8-1:0]      rsp_tdata,
   // inverse_exists
   output logic                                rsp_tuser
);

   localparam int OUT_RAW  = 4 * WIDTH + 2;
   localparam int OUT_BITS = ((OUT_RAW + 7) / 8) * 8;
   localparam int DW       = 2 * WIDTH - 1;
   localparam int CW       = $clog2(WIDTH);
   localparam logic [CW-1:0] CNT_TOP = CW'(WIDTH - 1);

   egcd_state_type state_ff, state_in;

   logic [WIDTH-1:0] r0_ff, r0_in;
   logic [WIDTH-1:0] r1_ff, r1_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [DW-1:0]    div_ff, div_in;
   logic [WIDTH-1:0] b_ff, b_in;
   logic [WIDTH:0]   s0_ff, s0_in, s1_ff, s1_in;
   logic [WIDTH:0]   t0_ff, t0_in, t1_ff, t1_in;
   logic [WIDTH:0]   acc_s_ff, acc_s_in, acc_t_ff, acc_t_in;
   logic [CW-1:0]    cnt_ff, cnt_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [OUT_BITS-1:0] rsp_data_ff, rsp_data_in;
   logic                rsp_user_ff, rsp_user_in;

   logic [WIDTH-1:0] in_a, in_b;
   logic             ge;
   logic [WIDTH-1:0] rem_next;
   logic [WIDTH:0]   acc_s_next, acc_t_next;
   logic             out_free;
   logic             exists;
   logic [WIDTH-1:0] inv_val;

   assign in_a = req_tdata[WIDTH-1:0];
   assign in_b = req_tdata[2*WIDTH-1:WIDTH];

   // shared quotient bit unit: compare, subtract and horner-accumulate q*s1, q*t1
   assign ge         = div_ff <= {{(WIDTH-1){1'b0}}, rem_ff};
   assign rem_next   = ge ? rem_ff - div_ff[WIDTH-1:0] : rem_ff;
   assign acc_s_next = {acc_s_ff[WIDTH-1:0], 1'b0} + (ge ? s1_ff : '0);
   assign acc_t_next = {acc_t_ff[WIDTH-1:0], 1'b0} + (ge ? t1_ff : '0);

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign exists   = (r0_ff == WIDTH'(1)) && (b_ff != '0);
   // |x| < b when the inverse exists, so one add folds a negative x into range
   assign inv_val  = !exists ? '0 : (s0_ff[WIDTH] ? s0_ff[WIDTH-1:0] + b_ff
                                                  : s0_ff[WIDTH-1:0]);

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      r0_ff       <= r0_in;
      r1_ff       <= r1_in;
      rem_ff      <= rem_in;
      div_ff      <= div_in;
      b_ff        <= b_in;
      s0_ff       <= s0_in;
      s1_ff       <= s1_in;
      t0_ff       <= t0_in;
      t1_ff       <= t1_in;
      acc_s_ff    <= acc_s_in;
      acc_t_ff    <= acc_t_in;
      cnt_ff      <= cnt_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   always_comb begin
      state_in     = state_ff;
      r0_in        = r0_ff;
      r1_in        = r1_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      b_in         = b_ff;
      s0_in        = s0_ff;
      s1_in        = s1_ff;
      t0_in        = t0_ff;
      t1_in        = t1_ff;
      acc_s_in     = acc_s_ff;
      acc_t_in     = acc_t_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               r0_in    = in_a;
               r1_in    = in_b;
               b_in     = in_b;
               s0_in    = (WIDTH+1)'(1);
               s1_in    = '0;
               t0_in    = '0;
               t1_in    = (WIDTH+1)'(1);
               rem_in   = in_a;
               div_in   = {in_b, {(WIDTH-1){1'b0}}};
               acc_s_in = '0;
               acc_t_in = '0;
               cnt_in   = CNT_TOP;
               state_in = (in_b == '0) ? ST_FIN : ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in   = rem_next;
            div_in   = div_ff >> 1;
            acc_s_in = acc_s_next;
            acc_t_in = acc_t_next;
            cnt_in   = cnt_ff - CW'(1);
            if (cnt_ff == '0) begin
               // step done: (r0, r1) <- (r1, r0 mod r1), coefficients likewise
               r0_in    = r1_ff;
               r1_in    = rem_next;
               s0_in    = s1_ff;
               s1_in    = s0_ff - acc_s_next;
               t0_in    = t1_ff;
               t1_in    = t0_ff - acc_t_next;
               rem_in   = r1_ff;
               div_in   = {rem_next, {(WIDTH-1){1'b0}}};
               acc_s_in = '0;
               acc_t_in = '0;
               cnt_in   = CNT_TOP;
               state_in = (rem_next == '0) ? ST_FIN : ST_DIV;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = OUT_BITS'({inv_val, t0_ff, s0_ff, r0_ff});
               rsp_user_in  = exists;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

`ifndef NO_ASSERTIONS
   // the divide step only runs on a nonzero divisor
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (r1_ff != '0))
      else $error("divide step with zero divisor");

   // an inverse is only flagged with a gcd of one
   a_exists_gcd: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_user_ff) |-> (rsp_data_ff[WIDTH-1:0] == WIDTH'(1)))
      else $error("inverse flagged with gcd other than one");

   // without an inverse the inverse field is zero
   a_no_inverse_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_user_ff) |-> (rsp_data_ff[4*WIDTH+1:3*WIDTH+2] == '0))
      else $error("inverse field nonzero without inverse");

   // finishing only loads the result register when it is free
   a_fin_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && rsp_valid_ff && !rsp_tready) |=> (state_ff == ST_FIN))
      else $error("result overwritten before it was taken");
`endif

endmodule

### verif/extended_gcd_mod_inverse_top_test.sv
// testbench for the extended gcd / modular inverse block against a local bezout predictor
`timescale 1ns / 1ps

module extended_gcd_mod_inverse_top_test;

   localparam int OPERAND_BITS = 32;
   localparam int COEF_BITS    = OPERAND_BITS + 1;
   localparam int REQ_BITS     = 2 * OPERAND_BITS;
   localparam int RSP_USED     = 2 * OPERAND_BITS + 2 * COEF_BITS;
   localparam int RSP_BITS     = ((RSP_USED + 7) / 8) * 8;
   localparam int MAX_QUOTS    = 2 * OPERAND_BITS + 8;
   localparam int HOLD_CYCLES  = 3000;
   localparam int SETTLE_CYCLES = 1600;
   localparam int MAX_PRINTS   = 60;

   localparam logic [OPERAND_BITS-1:0] ALL_ONES = '1;

   typedef struct {
      logic [OPERAND_BITS-1:0] operand_a;
      logic [OPERAND_BITS-1:0] modulus_b;
      logic [OPERAND_BITS-1:0] gcd_value;
      logic [COEF_BITS-1:0]    coef_x;
      logic [COEF_BITS-1:0]    coef_y;
      logic [OPERAND_BITS-1:0] inverse;
      logic                    inverse_exists;
   } bezout_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   // operand_a, modulus_b
   logic [REQ_BITS-1:0] req_tdata = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   // gcd_value, coef_x, coef_y, inverse, zero fill
   logic [RSP_BITS-1:0] rsp_tdata;
   // inverse_exists
   logic                rsp_tuser;

   bezout_result_type pending_results[$];
   int  mismatch_count = 0;
   bit  calm = 1'b0;
   int  hold_requests = 0;

   extended_gcd_mod_inverse_top #(
      .WIDTH(OPERAND_BITS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   initial begin
      forever begin
         #5 clock = ~clock;
      end
   end

   // forward pass keeps the quotients, backward pass builds x and y in 64-bit wraparound
   function automatic bezout_result_type predict_bezout(input logic [OPERAND_BITS-1:0] a,
                                                        input logic [OPERAND_BITS-1:0] b);
      logic [63:0] quot [0:MAX_QUOTS-1];
      logic [63:0] r0, r1, rem, x, y, t, mag, rm, b64;
      int n;
      bezout_result_type res;
      r0 = 64'(a);
      r1 = 64'(b);
      b64 = 64'(b);
      n = 0;
      while (r1 != 0 && n < MAX_QUOTS) begin
         quot[n] = r0 / r1;
         rem = r0 % r1;
         n++;
         r0 = r1;
         r1 = rem;
      end
      x = 64'd1;
      y = 64'd0;
      while (n > 0) begin
         n--;
         t = x;
         x = y;
         y = t - quot[n] * y;
      end
      res.operand_a = a;
      res.modulus_b = b;
      res.gcd_value = r0[OPERAND_BITS-1:0];
      res.coef_x = x[COEF_BITS-1:0];
      res.coef_y = y[COEF_BITS-1:0];
      res.inverse_exists = (r0 == 64'd1) && (b != 0);
      res.inverse = '0;
      if (res.inverse_exists) begin
         if (x[63]) begin
            mag = 64'd0 - x;
            rm = mag % b64;
            res.inverse = (rm == 0) ? '0 : OPERAND_BITS'(b64 - rm);
         end else begin
            res.inverse = OPERAND_BITS'(x % b64);
         end
      end
      return res;
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTS) begin
         $display("%0t ns: %s", $time, what);
      end
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) begin
         return 0;
      end
      if (r < 93) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 60);
   endfunction

   // drive one word, wait for the handshake, then queue its prediction
   task automatic send_operands(input logic [OPERAND_BITS-1:0] a,
                                input logic [OPERAND_BITS-1:0] b);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {b, a};
      do begin
         @(posedge clock);
      end while (!req_tready);
      pending_results.push_back(predict_bezout(a, b));
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // receiver: checks at the rising edge, decides ready at the falling edge
   initial begin
      int stall_left;
      int hold_left;
      int hold_seen;
      bezout_result_type want;
      stall_left = 0;
      hold_left = 0;
      hold_seen = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               report_mismatch($sformatf("unexpected result word %h", rsp_tdata));
            end else begin
               want = pending_results.pop_front();
               if (rsp_tdata[OPERAND_BITS-1:0] !== want.gcd_value)
                  report_mismatch($sformatf("gcd_value a=%0d b=%0d: got %0d want %0d",
                     want.operand_a, want.modulus_b, rsp_tdata[OPERAND_BITS-1:0],
                     want.gcd_value));
               if (rsp_tdata[OPERAND_BITS +: COEF_BITS] !== want.coef_x)
                  report_mismatch($sformatf("coef_x a=%0d b=%0d: got %h want %h",
                     want.operand_a, want.modulus_b, rsp_tdata[OPERAND_BITS +: COEF_BITS],
                     want.coef_x));
               if (rsp_tdata[OPERAND_BITS+COEF_BITS +: COEF_BITS] !== want.coef_y)
                  report_mismatch($sformatf("coef_y a=%0d b=%0d: got %h want %h",
                     want.operand_a, want.modulus_b,
                     rsp_tdata[OPERAND_BITS+COEF_BITS +: COEF_BITS], want.coef_y));
               if (rsp_tdata[OPERAND_BITS+2*COEF_BITS +: OPERAND_BITS] !== want.inverse)
                  report_mismatch($sformatf("inverse a=%0d b=%0d: got %0d want %0d",
                     want.operand_a, want.modulus_b,
                     rsp_tdata[OPERAND_BITS+2*COEF_BITS +: OPERAND_BITS], want.inverse));
               if (rsp_tdata[RSP_BITS-1:RSP_USED] !== '0)
                  report_mismatch($sformatf("fill bits a=%0d b=%0d: got %h",
                     want.operand_a, want.modulus_b, rsp_tdata[RSP_BITS-1:RSP_USED]));
               if (rsp_tuser !== want.inverse_exists)
                  report_mismatch($sformatf("inverse_exists a=%0d b=%0d: got %b want %b",
                     want.operand_a, want.modulus_b, rsp_tuser, want.inverse_exists));
            end
         end
         @(negedge clock);
         if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            stall_left = pick_gap();
            rsp_tready <= (stall_left == 0);
         end
      end
   end

   task automatic test_directed();
      send_operands(0, 0);
      send_operands(ALL_ONES, 0);
      send_operands(0, ALL_ONES);
      send_operands(0, 1);
      send_operands(ALL_ONES, 1);
      send_operands(1, ALL_ONES);
      send_operands(ALL_ONES, ALL_ONES);
      send_operands(ALL_ONES, ALL_ONES - 1);
      send_operands(ALL_ONES - 1, ALL_ONES);
      send_operands(3, 7);
      send_operands(7, 3);
      send_operands(6, 9);
      send_operands(12, 12);
      send_operands(1, 1);
      send_operands(5, 2);
      // consecutive fibonacci numbers: the longest euclid chain in 32 bits
      send_operands(32'd1836311903, 32'd2971215073);
      send_operands(32'd2971215073, 32'd1836311903);
      send_operands(32'h8000_0000, 32'h4000_0000);
      send_operands(32'h8000_0000, 32'h7fff_ffff);
      send_operands(32'h7fff_ffff, 32'h8000_0000);
      send_operands(32'haaaa_aaaa, 32'h5555_5555);
      send_operands(32'h5555_5555, 32'haaaa_aaab);
      send_operands(2, 32'h8000_0000);
   endtask

   task automatic test_random(input int count);
      logic [OPERAND_BITS-1:0] a, b, fa, fb, ft, g;
      int k;
      repeat (count) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               a = $urandom;
               b = $urandom;
            end
            4, 5: begin
               a = $urandom_range(0, 300);
               b = $urandom_range(0, 300);
            end
            6: begin
               g = $urandom_range(2, 1000);
               a = g * $urandom_range(0, 1 << 20);
               b = g * $urandom_range(0, 1 << 20);
            end
            7: begin
               fa = 1;
               fb = 1;
               k = $urandom_range(1, 45);
               repeat (k) begin
                  ft = fa + fb;
                  fa = fb;
                  fb = ft;
               end
               if ($urandom_range(0, 1)) begin
                  a = fa;
                  b = fb;
               end else begin
                  a = fb;
                  b = fa;
               end
            end
            8: begin
               a = $urandom;
               b = $urandom_range(0, 2);
               if ($urandom_range(0, 1)) begin
                  b = a;
                  a = $urandom_range(0, 1);
               end
            end
            default: begin
               a = $urandom;
               b = 32'd1 << $urandom_range(0, 31);
               if ($urandom_range(0, 1)) b = b | 1;
            end
         endcase
         send_operands(a, b);
      end
   endtask

   // receiver holds off for a long stretch while words keep coming
   task automatic test_backpressure();
      calm = 1'b1;
      hold_requests++;
      repeat (4) send_operands($urandom, 0);
      repeat (8) send_operands($urandom_range(0, 50), $urandom_range(1, 50));
      calm = 1'b0;
   endtask

   task automatic test_drain_pause();
      test_random(20);
      wait_drained();
      test_random(20);
   endtask

   task automatic test_no_idling();
      calm = 1'b1;
      test_random(60);
      calm = 1'b0;
   endtask

   initial begin
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_backpressure();
      test_random(600);
      test_no_idling();
      test_drain_pause();
      test_random(740);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("extended_gcd_mod_inverse_top verification clean");
      end else begin
         $display("extended_gcd_mod_inverse_top verification failed");
      end
      $finish;
   end

   initial begin
      #100ms;
      $display("extended_gcd_mod_inverse_top verification failed");
      $finish;
   end

endmodule
